// ----- hdl/frle_pkg.sv -----
// frle_pkg: types, constants and helpers for the float run-length encoder.
// Used by all modules of the block; no dependencies.
package frle_pkg;

	localparam int unsigned CNT_W  = 25;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = $clog2(QDEPTH);

	localparam logic [CNT_W-1:0]  MAX_RUN   = 25'd16777216;
	localparam logic [WORD_W-1:0] CAP_RESET = 32'hFFFF_FFFF;
	localparam logic [WORD_W-1:0] PAIR_WORDS = 32'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_CAP       = 2'd1;
	localparam logic [1:0] ST_LONG      = 2'd2;
	localparam logic [1:0] ST_NONFINITE = 2'd3;

	localparam logic [31:0] EXP_MASK  = 32'h7F80_0000;
	localparam logic [31:0] MAG_MASK  = 32'h7FFF_FFFF;

	typedef struct packed {
		logic [31:0] sample_bits;
		logic        end_of_vector;
	} sample_t;

	typedef struct packed {
		logic [31:0]      run_value;
		logic [CNT_W-1:0] run_count;
		logic [31:0]      count_float_bits;
		logic [1:0]       status;
		logic [31:0]      encoded_words;
		logic             vector_done;
		logic             last;
	} run_t;

	// up to two result beats produced by one sample
	typedef struct packed {
		logic [1:0] n;
		run_t       r1;
		run_t       r0;
	} run_pair_t;

	function automatic logic [31:0] count_to_float(input logic [CNT_W-1:0] c);
		logic [4:0]  p;
		logic [22:0] mant;
		logic [7:0]  expo;
		p = '0;
		for (int i = 0; i < CNT_W; i++) begin
			if (c[i]) begin
				p = 5'(i);
			end
		end
		if (p <= 5'd23) begin
			mant = 23'(c << (5'd23 - p));
		end else begin
			mant = 23'(c >> (p - 5'd23));
		end
		expo = 8'd127 + {3'd0, p};
		if (c == '0) begin
			count_to_float = '0;
		end else begin
			count_to_float = {1'b0, expo, mant};
		end
	endfunction

	function automatic logic room_for_pair(input logic [31:0] cap, input logic [31:0] ww);
		room_for_pair = (cap >= PAIR_WORDS) && (ww <= cap - PAIR_WORDS);
	endfunction

	function automatic run_t make_run(input logic [31:0] value, input logic [CNT_W-1:0] cnt,
			input logic [1:0] st, input logic [31:0] words, input logic done,
			input logic lst);
		run_t r;
		r.run_value        = value;
		r.run_count        = cnt;
		r.count_float_bits = count_to_float(cnt);
		r.status           = st;
		r.encoded_words    = words;
		r.vector_done      = done;
		r.last             = lst;
		make_run = r;
	endfunction

endpackage

// ----- hdl/frle_core.sv -----
// frle_core: run state and per-sample merge/flush/error logic.
// Depends on frle_pkg.
module frle_core
	import frle_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      take,
	input  sample_t   item,
	input  logic [31:0] cap,
	output run_pair_t res
);

	logic             open_q, drop_q;
	logic [31:0]      held_q, ww_q;
	logic [CNT_W-1:0] cnt_q;

	logic             open_d, drop_d;
	logic [31:0]      held_d, ww_d;
	logic [CNT_W-1:0] cnt_d;

	always_comb begin
		logic             failed;
		logic             k;
		logic             eov;
		logic             same;
		logic [31:0]      x;
		logic [31:0]      ww;
		logic [31:0]      hv;
		logic [CNT_W-1:0] hc;
		logic             ro;
		run_t             slot [2];

		x       = item.sample_bits;
		eov     = item.end_of_vector;
		failed  = 1'b0;
		k       = 1'b0;
		ww      = ww_q;
		hv      = held_q;
		hc      = cnt_q;
		ro      = open_q;
		slot[0] = '0;
		slot[1] = '0;
		open_d  = open_q;
		drop_d  = drop_q;
		held_d  = held_q;
		cnt_d   = cnt_q;
		ww_d    = ww_q;
		res.n   = 2'd0;

		same = ro && (x == hv || ((x & MAG_MASK) == '0 && (hv & MAG_MASK) == '0));

		if (drop_q) begin
			if (eov) begin
				drop_d = 1'b0;
				open_d = 1'b0;
				held_d = '0;
				cnt_d  = '0;
				ww_d   = '0;
			end
		end else begin
			if ((x & EXP_MASK) == EXP_MASK) begin
				failed  = 1'b1;
				slot[0] = make_run('0, '0, ST_NONFINITE, ww, eov, 1'b1);
				res.n   = 2'd1;
			end else if (same) begin
				if (hc >= MAX_RUN) begin
					failed  = 1'b1;
					slot[0] = make_run('0, '0, ST_LONG, ww, eov, 1'b1);
					res.n   = 2'd1;
				end else begin
					hc = hc + 1'b1;
				end
			end else begin
				if (ro) begin
					if (!room_for_pair(cap, ww)) begin
						failed  = 1'b1;
						slot[0] = make_run('0, '0, ST_CAP, ww, eov, 1'b1);
						res.n   = 2'd1;
					end else begin
						ww      = ww + PAIR_WORDS;
						slot[0] = make_run(hv, hc, ST_OK, ww, 1'b0, !eov);
						k       = 1'b1;
						res.n   = 2'd1;
					end
				end
				if (!failed) begin
					ro = 1'b1;
					hv = x;
					hc = CNT_W'(1);
				end
			end

			if (!failed && eov) begin
				if (hc > MAX_RUN) begin
					failed  = 1'b1;
					slot[k] = make_run('0, '0, ST_LONG, ww, 1'b1, 1'b1);
				end else if (!room_for_pair(cap, ww)) begin
					failed  = 1'b1;
					slot[k] = make_run('0, '0, ST_CAP, ww, 1'b1, 1'b1);
				end else begin
					slot[k] = make_run(hv, hc, ST_OK, ww + PAIR_WORDS, 1'b1, 1'b1);
				end
				res.n = k ? 2'd2 : 2'd1;
			end

			if (eov) begin
				open_d = 1'b0;
				held_d = '0;
				cnt_d  = '0;
				ww_d   = '0;
			end else if (failed) begin
				drop_d = 1'b1;
			end else begin
				open_d = ro;
				held_d = hv;
				cnt_d  = hc;
				ww_d   = ww;
			end
		end

		res.r0 = slot[0];
		res.r1 = slot[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			drop_q <= 1'b0;
			held_q <= '0;
			cnt_q  <= '0;
			ww_q   <= '0;
		end else if (take) begin
			open_q <= open_d;
			drop_q <= drop_d;
			held_q <= held_d;
			cnt_q  <= cnt_d;
			ww_q   <= ww_d;
		end
	end

endmodule

// ----- hdl/frle_outq.sv -----
// frle_outq: small result queue, up to two beats in, one beat out per cycle while run_ready is high.
// Depends on frle_pkg.
module frle_outq
	import frle_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  run_pair_t din,
	output logic      room2,
	output logic      run_valid,
	input  logic      run_ready,
	output run_t      run
);

	run_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;
	logic              pop;
	logic [QPTR_W:0]   n_in;
	logic [QPTR_W-1:0] wr_nxt;

	assign run_valid = (cnt_q != '0);
	assign run       = mem_q[rd_q];
	assign pop       = run_valid && run_ready;
	assign room2     = (cnt_q <= (QPTR_W+1)'(QDEPTH - 2));
	assign n_in      = push ? (QPTR_W+1)'(din.n) : '0;
	assign wr_nxt    = wr_q + 1'b1;

	always_ff @(posedge clk) begin
		if (push && din.n != 2'd0) begin
			mem_q[wr_q] <= din.r0;
		end
		if (push && din.n == 2'd2) begin
			mem_q[wr_nxt] <= din.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + QPTR_W'(n_in);
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + n_in - (QPTR_W+1)'(pop);
		end
	end

endmodule

// ----- hdl/float_run_length_encoder.sv -----
// float_run_length_encoder: top level, input register, run core, result queue.
// Path: a sample beat is held in the input register, the run core writes its result beats
//   into the result queue, and the queue offers them on the run port.
// Throughput: one sample per cycle while the queue has room for two beats; a sample that
//   flushes two runs sends them out one at a time via the single-beat read port of the queue.
// Reset: arst_n clears run state, queue and input register; capacity goes to all ones.
// Depends on frle_pkg, frle_core, frle_outq.
module float_run_length_encoder
	import frle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        sample_valid,
	output logic        sample_ready,
	input  sample_t     sample,
	output logic        run_valid,
	input  logic        run_ready,
	output run_t        run
);

	sample_t     item_s1;
	logic        valid_s1;
	logic [31:0] cap_q;
	logic        room2;
	logic        take;
	run_pair_t   res;

	assign take         = valid_s1 && room2;
	assign sample_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample_ready) begin
			valid_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_ready && sample_valid) begin
			item_s1 <= sample;
		end
	end

	frle_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.item   (item_s1),
		.cap    (cap_q),
		.res    (res)
	);

	frle_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take),
		.din       (res),
		.room2     (room2),
		.run_valid (run_valid),
		.run_ready (run_ready),
		.run       (run)
	);

endmodule

// ----- tb/sv/float_run_length_encoder_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for float_run_length_encoder: random and directed sample beats,
// run beats checked against an in-bench encoder of runs, capacity and error handling.
// Depends on frle_pkg and the float_run_length_encoder RTL.
module float_run_length_encoder_tb;
	import frle_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 200_000;
	localparam int unsigned DRAIN_CYCLES = 4;
	localparam int unsigned RAND_ITEMS   = 225;

	typedef struct packed {
		sample_t     beat;
		logic [31:0] reps;
	} burst_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;
	logic        sample_valid;
	logic        sample_ready;
	sample_t     sample;
	logic        run_valid;
	logic        run_ready;
	run_t        run;

	burst_t      sample_fifo[$];
	run_t        expected_runs[$];
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	logic        beat_taken;
	int unsigned mismatches;
	int unsigned cycle_count;

	logic [31:0]      cap_words;
	logic             open_run;
	logic [31:0]      run_val;
	logic [CNT_W-1:0] run_len;
	logic [31:0]      words_out;
	logic             dropping;

	float_run_length_encoder i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.run_valid    (run_valid),
		.run_ready    (run_ready),
		.run          (run)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [31:0] count_as_float(input logic [CNT_W-1:0] n);
		int          msb;
		logic [31:0] wide;
		msb  = 0;
		wide = {7'd0, n};
		if (n == '0) begin
			return 32'd0;
		end
		for (int b = 0; b < CNT_W; b++) begin
			if (n[b]) begin
				msb = b;
			end
		end
		if (msb <= 23) begin
			wide = wide << (23 - msb);
		end else begin
			wide = wide >> (msb - 23);
		end
		return {1'b0, 8'(127 + msb), wide[22:0]};
	endfunction

	function automatic logic pair_fits();
		return (cap_words >= PAIR_WORDS) && (words_out <= cap_words - PAIR_WORDS);
	endfunction

	task automatic clear_run_state();
		open_run  = 1'b0;
		run_val   = '0;
		run_len   = '0;
		words_out = '0;
		dropping  = 1'b0;
	endtask

	task automatic push_run(input logic [31:0] value, input logic [CNT_W-1:0] n,
			input logic [1:0] st, input logic done, input logic lst);
		run_t r;
		r.run_value        = value;
		r.run_count        = n;
		r.count_float_bits = count_as_float(n);
		r.status           = st;
		r.encoded_words    = words_out;
		r.vector_done      = done;
		r.last             = lst;
		expected_runs.push_back(r);
	endtask

	task automatic raise_error(input logic [1:0] st, input logic eov);
		push_run(32'd0, '0, st, eov, 1'b1);
		if (eov) begin
			clear_run_state();
		end else begin
			dropping = 1'b1;
		end
	endtask

	task automatic encode_beat(input sample_t s);
		logic [31:0] x;
		logic        eov;
		logic        same;
		x   = s.sample_bits;
		eov = s.end_of_vector;
		if (dropping) begin
			if (eov) begin
				clear_run_state();
			end
			return;
		end
		if ((x & EXP_MASK) == EXP_MASK) begin
			raise_error(ST_NONFINITE, eov);
			return;
		end
		// +0 and -0 compare equal
		same = open_run && (x == run_val ||
			((x & MAG_MASK) == '0 && (run_val & MAG_MASK) == '0));
		if (same) begin
			if (run_len >= MAX_RUN) begin
				raise_error(ST_LONG, eov);
				return;
			end
			run_len = run_len + 1'b1;
		end else begin
			if (open_run) begin
				if (!pair_fits()) begin
					raise_error(ST_CAP, eov);
					return;
				end
				words_out = words_out + PAIR_WORDS;
				push_run(run_val, run_len, ST_OK, 1'b0, !eov);
			end
			open_run = 1'b1;
			run_val  = x;
			run_len  = CNT_W'(1);
		end
		if (eov) begin
			if (run_len > MAX_RUN) begin
				raise_error(ST_LONG, 1'b1);
				return;
			end
			if (!pair_fits()) begin
				raise_error(ST_CAP, 1'b1);
				return;
			end
			words_out = words_out + PAIR_WORDS;
			push_run(run_val, run_len, ST_OK, 1'b1, 1'b1);
			clear_run_state();
		end
	endtask

	task automatic note_mismatch(input run_t want, input run_t got, input logic orphan);
		mismatches++;
		if (mismatches <= 10) begin
			if (orphan) begin
				$display("run beat with nothing expected: value=%h count=%0d fbits=%h",
					got.run_value, got.run_count, got.count_float_bits);
			end
			$display("mismatch exp: value=%h count=%0d fbits=%h st=%0d words=%0d done=%b last=%b",
				want.run_value, want.run_count, want.count_float_bits, want.status,
				want.encoded_words, want.vector_done, want.last);
			$display("         got: value=%h count=%0d fbits=%h st=%0d words=%0d done=%b last=%b",
				got.run_value, got.run_count, got.count_float_bits, got.status,
				got.encoded_words, got.vector_done, got.last);
		end
	endtask

	always @(negedge clk) begin
		burst_t head;
		if (arst_n) begin
			if (beat_taken) begin
				head = sample_fifo.pop_front();
				if (head.reps > 1) begin
					head.reps = head.reps - 1;
					sample_fifo.push_front(head);
				end
			end
			if (!sample_valid || beat_taken) begin
				if (sample_fifo.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					sample       <= sample_fifo[0].beat;
					sample_valid <= 1'b1;
				end else begin
					sample_valid <= 1'b0;
				end
			end
			run_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		run_t want;
		if (arst_n) begin
			if (run_valid && run_ready) begin
				if (expected_runs.size() == 0) begin
					note_mismatch('0, run, 1'b1);
				end else begin
					want = expected_runs.pop_front();
					if (want.run_value !== run.run_value
							|| want.run_count !== run.run_count
							|| want.count_float_bits !== run.count_float_bits
							|| want.status !== run.status
							|| want.encoded_words !== run.encoded_words
							|| want.vector_done !== run.vector_done
							|| want.last !== run.last) begin
						note_mismatch(want, run, 1'b0);
					end
				end
			end
			if (sample_valid && sample_ready) begin
				encode_beat(sample);
			end
		end
		beat_taken = arst_n && sample_valid && sample_ready;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic add_beats(input logic [31:0] bits, input logic eov, input logic [31:0] reps);
		burst_t b;
		b.beat.sample_bits   = bits;
		b.beat.end_of_vector = eov;
		b.reps               = reps;
		sample_fifo.push_back(b);
	endtask

	task automatic wait_idle();
		while (sample_fifo.size() != 0 || sample_valid || expected_runs.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [31:0] v);
		@(negedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en   <= 1'b0;
		cap_words = v;
	endtask

	task automatic random_vectors(input int unsigned n_items);
		int unsigned sent;
		int unsigned len;
		int unsigned pick;
		logic [31:0] v;
		logic [31:0] prev;
		sent = 0;
		prev = '0;
		while (sent < n_items) begin
			len = $urandom_range(10, 1);
			if ($urandom_range(15) == 0) begin
				len = $urandom_range(40, 11);
			end
			for (int i = 0; i < len; i++) begin
				pick = $urandom_range(99);
				if (pick < 45) begin
					v = prev;
				end else if (pick < 60) begin
					v = {1'($urandom_range(1)), 31'd0};
				end else if (pick < 75) begin
					v = {1'($urandom_range(1)), 31'(32'h3F80_0000 + $urandom_range(2))};
				end else if (pick < 96) begin
					v = $urandom;
				end else begin
					v = {1'($urandom_range(1)), 8'hFF, 23'($urandom)};
				end
				add_beats(v, i == len - 1, 1);
				prev = v;
			end
			sent += len;
		end
	endtask

	initial begin
		logic [31:0] phase_cap[4];
		int unsigned phase_send[4];
		int unsigned phase_recv[4];
		phase_cap  = '{32'hFFFF_FFFE, 32'd16, 32'd6, 32'hFFFF_FFFF};
		phase_send = '{0, 60, 0, 25};
		phase_recv = '{0, 0, 60, 25};
		arst_n         = 1'b0;
		cfg_wr_en      = 1'b0;
		cfg_wr_data    = '0;
		sample_valid   = 1'b0;
		sample         = '0;
		run_ready      = 1'b0;
		beat_taken     = 1'b0;
		mismatches     = 0;
		cycle_count    = 0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		cap_words      = CAP_RESET;
		clear_run_state();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// signed zeros merge, denormal, largest finite values
		add_beats(32'h0000_0000, 1'b0, 1);
		add_beats(32'h8000_0000, 1'b0, 1);
		add_beats(32'h8000_0000, 1'b0, 1);
		add_beats(32'h3F80_0000, 1'b0, 1);
		add_beats(32'h3F80_0000, 1'b0, 1);
		add_beats(32'h0000_0001, 1'b0, 1);
		add_beats(32'h7F7F_FFFF, 1'b0, 1);
		add_beats(32'hFF7F_FFFF, 1'b1, 1);
		// non-finite mid vector, then dropped beats
		add_beats(32'h4000_0000, 1'b0, 1);
		add_beats(32'h7F80_0000, 1'b0, 1);
		add_beats(32'h1234_5678, 1'b0, 1);
		add_beats(32'hFFFF_FFFF, 1'b1, 1);
		// non-finite on the last element
		add_beats(32'h4000_0000, 1'b0, 1);
		add_beats(32'hFF80_0001, 1'b1, 1);
		add_beats(32'h7FC0_0000, 1'b1, 1);
		// two runs flushed by the final beat
		add_beats(32'hC000_0000, 1'b0, 1);
		add_beats(32'h8000_0000, 1'b1, 1);
		wait_idle();

		write_capacity(32'd0);
		add_beats(32'h3F80_0000, 1'b0, 1);
		add_beats(32'h4000_0000, 1'b0, 1);
		add_beats(32'h4040_0000, 1'b1, 1);
		wait_idle();
		write_capacity(32'd1);
		add_beats(32'h40A0_0000, 1'b1, 1);
		wait_idle();
		write_capacity(32'd4);
		add_beats(32'h3F80_0000, 1'b0, 1);
		add_beats(32'h4000_0000, 1'b0, 1);
		add_beats(32'h4040_0000, 1'b1, 1);
		wait_idle();
		write_capacity(32'd2);
		add_beats(32'h3F80_0000, 1'b0, 1);
		add_beats(32'h4000_0000, 1'b1, 1);
		wait_idle();

		for (int ph = 0; ph < 4; ph++) begin
			write_capacity(phase_cap[ph]);
			send_idle_pct  = phase_send[ph];
			recv_stall_pct = phase_recv[ph];
			random_vectors(RAND_ITEMS);
			wait_idle();
		end

		if (mismatches == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
